/* rtl/scpb_pkg.sv */
// Package with types, codes and helpers for the sound CPU port bridge.
`timescale 1ns / 1ps
package scpb_pkg;

  localparam logic [1:0] OP_PORT_WR = 2'd0;
  localparam logic [1:0] OP_PORT_RD = 2'd1;
  localparam logic [1:0] OP_CMD_WR  = 2'd2;
  localparam logic [1:0] OP_NOP     = 2'd3;

  localparam logic [4:0] OFF_DIR_ONE  = 5'd0;
  localparam logic [4:0] OFF_DIR_TWO  = 5'd1;
  localparam logic [4:0] OFF_PORT_ONE = 5'd2;
  localparam logic [4:0] OFF_PORT_TWO = 5'd3;

  localparam int STROBE_BIT  = 0;
  localparam int ADDR_BIT    = 2;
  localparam int CHIP0_BIT   = 3;
  localparam int CHIP1_BIT   = 4;
  localparam int CMD_IRQ_BIT = 7;

  typedef struct packed {
    logic [1:0] op;
    logic [4:0] reg_offset;
    logic [7:0] write_data;
    logic [7:0] chip0_port_in;
    logic [7:0] chip1_port_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       chip_write;
    logic       chip_select;
    logic       chip_is_address;
    logic [7:0] chip_bus_data;
    logic       latch_write;
    logic [6:0] latch_data;
    logic       irq_request;
  } out_item_t;

  function automatic logic [7:0] merge_bits(input logic [7:0] old_val,
                                            input logic [7:0] new_val,
                                            input logic [7:0] dir);
    merge_bits = (old_val & ~dir) | (new_val & dir);
  endfunction

endpackage

/* rtl/scpb_if.sv */
// Handshake channel interfaces for the sound CPU port bridge.
`timescale 1ns / 1ps
interface scpb_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [4:0] reg_offset;
  logic [7:0] write_data;
  logic [7:0] chip0_port_in;
  logic [7:0] chip1_port_in;

  modport source (output valid, output op, output reg_offset, output write_data,
                  output chip0_port_in, output chip1_port_in, input ready);
  modport sink (input valid, input op, input reg_offset, input write_data,
                input chip0_port_in, input chip1_port_in, output ready);
endinterface

interface scpb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       chip_write;
  logic       chip_select;
  logic       chip_is_address;
  logic [7:0] chip_bus_data;
  logic       latch_write;
  logic [6:0] latch_data;
  logic       irq_request;

  modport source (output valid, output read_data, output chip_write,
                  output chip_select, output chip_is_address, output chip_bus_data,
                  output latch_write, output latch_data, output irq_request,
                  input ready);
  modport sink (input valid, input read_data, input chip_write,
                input chip_select, input chip_is_address, input chip_bus_data,
                input latch_write, input latch_data, input irq_request,
                output ready);
endinterface

/* rtl/sound_cpu_port_psg_bridge_top.sv */
// Sound CPU port bridge: two I/O ports with direction registers driving two sound chips.
// Each beat on in_ch is one CPU bus access and yields exactly one beat on out_ch.
// A new beat is taken every cycle while out_ch is not stalled; the input register and
// the result register are the only pipeline stages, in that order, and the port and
// direction registers are updated as each beat passes from one to the other.
`timescale 1ns / 1ps
module sound_cpu_port_psg_bridge_top (
  input logic       clk,
  input logic       rst_n,
  scpb_in_if.sink   in_ch,
  scpb_out_if.source out_ch
);
  import scpb_pkg::*;

  logic       in_v_r;
  in_item_t   in_r;
  logic       out_v_r;
  out_item_t  out_r;
  out_item_t  out_nxt;
  logic [7:0] port_one_r, port_one_nxt;
  logic [7:0] port_two_r, port_two_nxt;
  logic [7:0] dir_one_r, dir_one_nxt;
  logic [7:0] dir_two_r, dir_two_nxt;
  logic       advance;
  logic       proc;

  assign advance     = !out_v_r || out_ch.ready;
  assign proc        = in_v_r && advance;
  assign in_ch.ready = !in_v_r || advance;

  always_comb begin
    logic [7:0] p2_new;
    logic       strobe_fall;
    out_nxt      = '0;
    port_one_nxt = port_one_r;
    port_two_nxt = port_two_r;
    dir_one_nxt  = dir_one_r;
    dir_two_nxt  = dir_two_r;
    p2_new       = merge_bits(port_two_r, in_r.write_data, dir_two_r);
    strobe_fall  = port_two_r[STROBE_BIT] && !p2_new[STROBE_BIT];
    unique case (in_r.op)
      OP_PORT_WR: begin
        unique case (in_r.reg_offset)
          OFF_DIR_ONE:  dir_one_nxt = in_r.write_data;
          OFF_DIR_TWO:  dir_two_nxt = in_r.write_data;
          OFF_PORT_ONE: port_one_nxt = merge_bits(port_one_r, in_r.write_data, dir_one_r);
          OFF_PORT_TWO: begin
            port_two_nxt = p2_new;
            if (strobe_fall && (port_two_r[CHIP1_BIT] || port_two_r[CHIP0_BIT])) begin
              out_nxt.chip_write      = 1'b1;
              out_nxt.chip_select     = port_two_r[CHIP1_BIT];
              out_nxt.chip_is_address = port_two_r[ADDR_BIT];
              out_nxt.chip_bus_data   = port_one_r;
            end
          end
          default: ;
        endcase
      end
      OP_PORT_RD: begin
        unique case (in_r.reg_offset)
          OFF_DIR_ONE: out_nxt.read_data = dir_one_r;
          OFF_DIR_TWO: out_nxt.read_data = dir_two_r;
          OFF_PORT_ONE: begin
            priority if (port_two_r[CHIP1_BIT]) begin
              out_nxt.read_data = merge_bits(in_r.chip1_port_in, port_one_r, dir_one_r);
            end else if (port_two_r[CHIP0_BIT]) begin
              out_nxt.read_data = merge_bits(in_r.chip0_port_in, port_one_r, dir_one_r);
            end else begin
              out_nxt.read_data = '0;
            end
          end
          default: ;
        endcase
      end
      OP_CMD_WR: begin
        if (in_r.write_data[CMD_IRQ_BIT]) begin
          out_nxt.irq_request = 1'b1;
        end else begin
          out_nxt.latch_write = 1'b1;
          out_nxt.latch_data  = in_r.write_data[6:0];
        end
      end
      OP_NOP: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r     <= 1'b0;
      out_v_r    <= 1'b0;
      port_one_r <= '0;
      port_two_r <= '0;
      dir_one_r  <= '0;
      dir_two_r  <= '0;
    end else begin
      if (in_ch.ready) begin
        in_v_r <= in_ch.valid;
      end
      if (advance) begin
        out_v_r <= in_v_r;
      end
      if (proc) begin
        port_one_r <= port_one_nxt;
        port_two_r <= port_two_nxt;
        dir_one_r  <= dir_one_nxt;
        dir_two_r  <= dir_two_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_r.op            <= in_ch.op;
      in_r.reg_offset    <= in_ch.reg_offset;
      in_r.write_data    <= in_ch.write_data;
      in_r.chip0_port_in <= in_ch.chip0_port_in;
      in_r.chip1_port_in <= in_ch.chip1_port_in;
    end
    if (proc) begin
      out_r <= out_nxt;
    end
  end

  assign out_ch.valid           = out_v_r;
  assign out_ch.read_data       = out_r.read_data;
  assign out_ch.chip_write      = out_r.chip_write;
  assign out_ch.chip_select     = out_r.chip_select;
  assign out_ch.chip_is_address = out_r.chip_is_address;
  assign out_ch.chip_bus_data   = out_r.chip_bus_data;
  assign out_ch.latch_write     = out_r.latch_write;
  assign out_ch.latch_data      = out_r.latch_data;
  assign out_ch.irq_request     = out_r.irq_request;

endmodule
